// File: src/emgenv_pkg.sv
// Shared constants, state encodings and unit handshake types for the EMG
// moving-average / RMS envelope block. No dependencies.
`default_nettype none

package emgenv_pkg;

  // Window and record geometry
  localparam int WINDOW     = 20;
  localparam int MAX_RECORD = 65536;
  localparam int HALF       = WINDOW / 2;
  localparam int RDEPTH     = 2 * HALF + 1;
  localparam int SDEPTH     = 2 * HALF;

  localparam int RAW_AW = $clog2(RDEPTH);
  localparam int SM_AW  = $clog2(SDEPTH);
  localparam int KW     = $clog2(MAX_RECORD);
  localparam int PW     = KW + 2;
  localparam int CW     = $clog2(RDEPTH + 1);

  // Arithmetic widths
  localparam int MAGW     = 15 + $clog2(RDEPTH);
  localparam int SUMW     = MAGW + 1;
  localparam int ENVW     = 31 + $clog2(SDEPTH);
  localparam int EW       = 31 + $clog2(MAX_RECORD);
  localparam int DW       = EW;
  localparam int NW       = KW + 1;
  localparam int NBW      = $clog2(DW + 1);
  localparam int SQW      = 32;
  localparam int SQ_STEPS = 16;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RAW,
    ST_SM_SETUP,
    ST_WALK,
    ST_SM_DIV,
    ST_SM_WAIT,
    ST_SM_WRITE,
    ST_J_NEXT,
    ST_EM_SETUP,
    ST_EM_DIV,
    ST_EM_WAIT,
    ST_RR_DIV,
    ST_RR_WAIT,
    ST_RS_DIV,
    ST_RS_WAIT,
    ST_OUT,
    ST_NEXT,
    ST_CLEAR
  } seq_state_t;

  typedef enum logic [1:0] {
    AR_IDLE,
    AR_DIV,
    AR_ROOT,
    AR_DONE
  } arith_state_t;

  typedef struct packed {
    logic           start;
    logic           do_root;
    logic [NBW-1:0] nbits;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] root;
  } arith_rsp_t;

endpackage

`default_nettype wire

// File: src/emg_average_rms_envelope.sv
// Centered moving average with RMS envelope over a marked record of samples.
// Per sample, the work is set by the shared divide/root unit and the RAM walks,
// plus any output stalls.
// The marked sample flushes up to 2*HALF results; the final one adds two EW-bit
// divides and roots.
// Reset: synchronous; record state clears, delay RAMs hold garbage until used.
`default_nettype none

module emg_average_rms_envelope (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [15:0] sample,
  input  logic               end_of_record,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [15:0]        position,
  output logic signed [15:0] smoothed,
  output logic [15:0]        envelope,
  output logic               final_res,
  output logic [15:0]        peak_envelope,
  output logic [15:0]        peak_position,
  output logic [15:0]        record_rms_raw,
  output logic [15:0]        record_rms_smoothed
);

  import emgenv_pkg::*;

  localparam logic signed [PW-1:0] HALF_S = PW'(HALF);
  localparam logic signed [PW-1:0] ONE_S  = PW'(1);
  localparam logic signed [PW-1:0] TWO_S  = PW'(2);

  seq_state_t state, state_next;

  // Record state
  logic [KW-1:0]     k;           // index of the current sample
  logic [RAW_AW-1:0] wptr;        // raw ring slot of sample k
  logic [SM_AW-1:0]  sptr;        // smoothed ring slot of the newest smoothed value
  logic [EW-1:0]     raw_energy;
  logic [EW-1:0]     smoothed_energy;
  logic [15:0]       peak_value;
  logic [15:0]       peak_at;

  // Per-sample sequencing
  logic signed [15:0]   x;
  logic                 last;
  logic signed [PW-1:0] j, j_end, p;
  logic                 fin;
  logic                 loop2;

  // Window walk
  logic                 walk_env;
  logic [RAW_AW-1:0]    raw_raddr;
  logic [SM_AW-1:0]     sm_raddr;
  logic signed [PW-1:0] pos, rd_pos;
  logic [CW-1:0]        cnt, wcount;
  logic                 rd_vld;
  logic signed [SUMW-1:0] sm_acc;
  logic [ENVW-1:0]      env_acc;

  // Results
  logic signed [15:0] sm_val;
  logic signed [15:0] sm_out;
  logic [15:0]        env;
  logic [15:0]        rr, rs;

  // RAM ports
  logic signed [15:0] raw_q, sm_q;
  logic [SM_AW-1:0]   sptr_inc;

  // Arithmetic unit
  arith_req_t    areq;
  arith_rsp_t    arsp;
  logic [DW-1:0] adividend;
  logic [NW-1:0] adivisor;
  logic [DW-1:0] aquo;

  // Index arithmetic
  logic signed [PW-1:0] kpos, k1, k2, jstart, p2, pe, j_lo, p_lo;
  logic [CW-1:0]        sm_count, em_count;
  logic signed [31:0]   xsq, smsq, rdsq;
  logic [SUMW-1:0]      sm_neg;
  logic [MAGW-1:0]      sm_mag;
  logic signed [15:0]   q16;
  logic                 out_free;

  assign kpos     = signed'({2'b00, k});
  assign k1       = kpos - HALF_S;
  assign k2       = kpos - HALF_S + TWO_S;
  assign jstart   = k1[PW-1] ? '0 : k1;
  assign p2       = k2[PW-1] ? '0 : k2;
  assign pe       = j - HALF_S + ONE_S;
  assign j_lo     = (j < HALF_S) ? '0 : j - HALF_S;
  assign p_lo     = (p < HALF_S) ? '0 : p - HALF_S;
  // Smoothed window ends at the newest sample; envelope window at newest j
  assign sm_count = CW'(kpos - j_lo + ONE_S);
  assign em_count = CW'(j - p_lo + ONE_S);

  assign xsq  = x * x;
  assign smsq = sm_val * sm_val;
  assign rdsq = sm_q * sm_q;

  assign sm_neg = -sm_acc;
  assign sm_mag = sm_acc[SUMW-1] ? MAGW'(sm_neg) : MAGW'(sm_acc);
  assign q16    = signed'(aquo[15:0]);

  assign sptr_inc = (sptr == SM_AW'(SDEPTH - 1)) ? '0 : sptr + SM_AW'(1);
  assign out_free = !result_valid || !result_stall;

  assign sample_stall = (state != ST_IDLE);

  // Raw sample ring, one slot per sample of the last 2*HALF+1
  emgenv_ram #(
    .WIDTH(16),
    .DEPTH(RDEPTH)
  ) u_raw_ram (
    .clk  (clk),
    .we   (state == ST_RAW),
    .waddr(wptr),
    .wdata(x),
    .raddr(raw_raddr),
    .rdata(raw_q)
  );

  // Smoothed value ring, the last 2*HALF values
  emgenv_ram #(
    .WIDTH(16),
    .DEPTH(SDEPTH)
  ) u_sm_ram (
    .clk  (clk),
    .we   (state == ST_SM_WRITE),
    .waddr(sptr_inc),
    .wdata(sm_val),
    .raddr(sm_raddr),
    .rdata(sm_q)
  );

  // Divide request: mean of a window or of the whole record, rooted for envelope and RMS
  always_comb begin
    areq.start   = 1'b0;
    areq.do_root = 1'b1;
    areq.nbits   = NBW'(EW);
    adividend    = raw_energy;
    adivisor     = NW'(wcount);
    case (state)
      ST_SM_DIV: begin
        areq.start   = 1'b1;
        areq.do_root = 1'b0;
        areq.nbits   = NBW'(MAGW);
        adividend    = DW'(sm_mag);
      end
      ST_SM_WAIT: begin
        areq.do_root = 1'b0;
        areq.nbits   = NBW'(MAGW);
        adividend    = DW'(sm_mag);
      end
      ST_EM_DIV, ST_EM_WAIT: begin
        areq.start = (state == ST_EM_DIV);
        areq.nbits = NBW'(ENVW);
        adividend  = DW'(env_acc);
      end
      ST_RR_DIV, ST_RR_WAIT: begin
        areq.start = (state == ST_RR_DIV);
        adivisor   = {1'b0, k} + NW'(1);
      end
      ST_RS_DIV, ST_RS_WAIT: begin
        areq.start = (state == ST_RS_DIV);
        adividend  = smoothed_energy;
        adivisor   = {1'b0, k} + NW'(1);
      end
      default: ;
    endcase
  end

  emgenv_arith u_arith (
    .clk     (clk),
    .rst     (rst),
    .req     (areq),
    .dividend(adividend),
    .divisor (adivisor),
    .rsp     (arsp),
    .quotient(aquo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (sample_valid) state_next = ST_RAW;
      // Skip all work until the first window is centered
      ST_RAW:      state_next = (last || !k1[PW-1]) ? ST_SM_SETUP : ST_NEXT;
      ST_SM_SETUP: state_next = ST_WALK;
      ST_WALK: begin
        if (cnt == '0 && !rd_vld) state_next = walk_env ? ST_EM_DIV : ST_SM_DIV;
      end
      ST_SM_DIV:   state_next = ST_SM_WAIT;
      ST_SM_WAIT:  if (arsp.done) state_next = ST_SM_WRITE;
      ST_SM_WRITE: state_next = pe[PW-1] ? ST_J_NEXT : ST_EM_SETUP;
      ST_J_NEXT: begin
        if (j != j_end)  state_next = ST_SM_SETUP;
        else if (last)   state_next = ST_EM_SETUP;
        else             state_next = ST_NEXT;
      end
      ST_EM_SETUP: state_next = ST_WALK;
      ST_EM_DIV:   state_next = ST_EM_WAIT;
      ST_EM_WAIT:  if (arsp.done) state_next = fin ? ST_RR_DIV : ST_OUT;
      ST_RR_DIV:   state_next = ST_RR_WAIT;
      ST_RR_WAIT:  if (arsp.done) state_next = ST_RS_DIV;
      ST_RS_DIV:   state_next = ST_RS_WAIT;
      ST_RS_WAIT:  if (arsp.done) state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          if (fin)        state_next = ST_CLEAR;
          else if (loop2) state_next = ST_EM_SETUP;
          else            state_next = ST_J_NEXT;
        end
      end
      ST_NEXT:     state_next = ST_IDLE;
      ST_CLEAR:    state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Record and walk datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      k               <= '0;
      wptr            <= '0;
      sptr            <= SM_AW'(SDEPTH - 1);
      raw_energy      <= '0;
      smoothed_energy <= '0;
      peak_value      <= '0;
      peak_at         <= '0;
      rd_vld          <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            x    <= sample;
            // A record that fills up ends on this sample
            last <= end_of_record || (k == KW'(MAX_RECORD - 1));
          end
        end
        ST_RAW: begin
          raw_energy <= raw_energy + EW'($unsigned(xsq));
          loop2      <= 1'b0;
          if (last) begin
            j     <= jstart;
            j_end <= kpos;
          end else begin
            j     <= k1;
            j_end <= k1;
          end
        end
        ST_SM_SETUP: begin
          raw_raddr <= wptr;
          pos       <= kpos;
          cnt       <= sm_count;
          wcount    <= sm_count;
          sm_acc    <= '0;
          walk_env  <= 1'b0;
        end
        ST_EM_SETUP: begin
          sm_raddr <= sptr;
          pos      <= j;
          cnt      <= em_count;
          wcount   <= em_count;
          env_acc  <= '0;
          walk_env <= 1'b1;
        end
        ST_WALK: begin
          // Walk each ring backward from its newest entry, one read a cycle
          if (cnt != '0) begin
            cnt       <= cnt - CW'(1);
            pos       <= pos - ONE_S;
            rd_pos    <= pos;
            rd_vld    <= 1'b1;
            raw_raddr <= (raw_raddr == '0) ? RAW_AW'(RDEPTH - 1) : raw_raddr - RAW_AW'(1);
            sm_raddr  <= (sm_raddr == '0) ? SM_AW'(SDEPTH - 1) : sm_raddr - SM_AW'(1);
          end else begin
            rd_vld <= 1'b0;
          end
          if (rd_vld) begin
            if (walk_env) begin
              env_acc <= env_acc + ENVW'($unsigned(rdsq));
              if (rd_pos == p) sm_out <= sm_q;
            end else begin
              sm_acc <= sm_acc + SUMW'(raw_q);
            end
          end
        end
        ST_SM_WAIT: begin
          // Truncate toward zero: divide the magnitude, restore the sign
          if (arsp.done) sm_val <= sm_acc[SUMW-1] ? -q16 : q16;
        end
        ST_SM_WRITE: begin
          sptr            <= sptr_inc;
          smoothed_energy <= smoothed_energy + EW'($unsigned(smsq));
          if (!pe[PW-1]) begin
            p   <= pe;
            fin <= last && (pe == kpos);
          end
        end
        ST_J_NEXT: begin
          if (j != j_end) begin
            j <= j + ONE_S;
          end else if (last) begin
            // Flush the envelopes whose windows run past the record end
            loop2 <= 1'b1;
            p     <= p2;
            fin   <= (p2 == kpos);
          end
        end
        ST_EM_WAIT: begin
          if (arsp.done) begin
            env <= arsp.root;
            if (arsp.root > peak_value) begin
              peak_value <= arsp.root;
              peak_at    <= 16'(p);
            end
          end
        end
        ST_RR_WAIT: if (arsp.done) rr <= arsp.root;
        ST_RS_WAIT: if (arsp.done) rs <= arsp.root;
        ST_OUT: begin
          if (out_free && loop2 && !fin) begin
            p   <= p + ONE_S;
            fin <= (p + ONE_S == kpos);
          end
        end
        ST_NEXT: begin
          k    <= k + KW'(1);
          wptr <= (wptr == RAW_AW'(RDEPTH - 1)) ? '0 : wptr + RAW_AW'(1);
        end
        ST_CLEAR: begin
          k               <= '0;
          wptr            <= '0;
          sptr            <= SM_AW'(SDEPTH - 1);
          raw_energy      <= '0;
          smoothed_energy <= '0;
          peak_value      <= '0;
          peak_at         <= '0;
        end
        default: ;
      endcase
    end
  end

  // Output register: hold the word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) result_valid <= 1'b1;
      else if (result_valid && !result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      position            <= 16'(p);
      smoothed            <= sm_out;
      envelope            <= env;
      final_res           <= fin;
      peak_envelope       <= fin ? peak_value : 16'd0;
      peak_position       <= fin ? peak_at : 16'd0;
      record_rms_raw      <= fin ? rr : 16'd0;
      record_rms_smoothed <= fin ? rs : 16'd0;
    end
  end

endmodule

`default_nettype wire

// File: src/emgenv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module emgenv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/emgenv_arith.sv
// Shared iterative unit: restoring divide one bit per cycle, then an
// optional floor square root two bits per cycle. Uses emgenv_pkg.
`default_nettype none

module emgenv_arith (
  input  logic                      clk,
  input  logic                      rst,
  input  emgenv_pkg::arith_req_t    req,
  input  logic [emgenv_pkg::DW-1:0] dividend,
  input  logic [emgenv_pkg::NW-1:0] divisor,
  output emgenv_pkg::arith_rsp_t    rsp,
  output logic [emgenv_pkg::DW-1:0] quotient
);

  import emgenv_pkg::*;

  arith_state_t   phase, phase_next;
  logic [DW-1:0]  dsh;
  logic [DW-1:0]  quo;
  logic [NW-1:0]  dvs;
  logic [NW-1:0]  rem;
  logic [NBW-1:0] steps;
  logic           do_root;
  logic [SQW-1:0] v;
  logic [SQW-1:0] res;
  logic [SQW-1:0] bitv;

  logic [NW:0]    trial;
  logic [NW:0]    trial_sub;
  logic           take;
  logic [SQW:0]   rb;
  logic           root_take;
  logic [DW-1:0]  quo_next;

  assign trial     = {rem, dsh[DW-1]};
  assign take      = trial >= {1'b0, dvs};
  assign trial_sub = trial - {1'b0, dvs};
  assign quo_next  = {quo[DW-2:0], take};
  assign rb        = {1'b0, res} + {1'b0, bitv};
  assign root_take = {1'b0, v} >= rb;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= AR_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      AR_IDLE: if (req.start) phase_next = AR_DIV;
      AR_DIV:  if (steps == NBW'(1)) phase_next = do_root ? AR_ROOT : AR_DONE;
      AR_ROOT: if (steps == NBW'(1)) phase_next = AR_DONE;
      AR_DONE: phase_next = AR_IDLE;
      default: phase_next = AR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (phase)
      AR_IDLE: begin
        if (req.start) begin
          dsh     <= dividend << (DW - int'(req.nbits));
          quo     <= '0;
          rem     <= '0;
          dvs     <= divisor;
          steps   <= req.nbits;
          do_root <= req.do_root;
        end
      end
      AR_DIV: begin
        rem   <= take ? trial_sub[NW-1:0] : trial[NW-1:0];
        quo   <= quo_next;
        dsh   <= dsh << 1;
        if (steps == NBW'(1)) begin
          v     <= SQW'(quo_next);
          res   <= '0;
          bitv  <= SQW'(1) << (SQW - 2);
          steps <= NBW'(SQ_STEPS);
        end else begin
          steps <= steps - NBW'(1);
        end
      end
      AR_ROOT: begin
        if (root_take) begin
          v   <= v - rb[SQW-1:0];
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv  <= bitv >> 2;
        steps <= steps - NBW'(1);
      end
      default: ;
    endcase
  end

  assign rsp.done = (phase == AR_DONE);
  assign rsp.root = res[15:0];
  assign quotient = quo;

endmodule

`default_nettype wire

// File: src/emgenv_chk.sv
// Port-level checker for emg_average_rms_envelope, bound to the top level.
// No package dependencies.
`default_nettype none

module emgenv_chk (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_stall,
  input logic signed [15:0] sample,
  input logic               end_of_record,
  input logic               result_valid,
  input logic               result_stall,
  input logic [15:0]        position,
  input logic signed [15:0] smoothed,
  input logic [15:0]        envelope,
  input logic               final_res,
  input logic [15:0]        peak_envelope,
  input logic [15:0]        peak_position,
  input logic [15:0]        record_rms_raw,
  input logic [15:0]        record_rms_smoothed
);

  // An accepted word keeps the input side busy in the cycle after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("input accepted twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(position) && $stable(smoothed) && $stable(final_res))
    else $error("stalled result word changed");

  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !final_res |->
      peak_envelope == 16'd0 && peak_position == 16'd0 &&
      record_rms_raw == 16'd0 && record_rms_smoothed == 16'd0)
    else $error("summary fields set on a non-final word");

  a_peak_covers_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && final_res |-> peak_envelope >= envelope)
    else $error("peak envelope below final envelope");

endmodule

bind emg_average_rms_envelope emgenv_chk u_emgenv_chk (.*);

`default_nettype wire
